// ----- sv/fsi_pkg.sv -----
// Shared types and constants of the FASTA stream indexer.
package fsi_pkg;

  localparam int unsigned OffsetBitsDefault = 40;
  localparam int unsigned BaseBitsDefault   = 32;

  localparam int unsigned PosW    = 40;
  localparam int unsigned CntW    = 32;
  localparam int unsigned StrideW = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;

  localparam logic [StrideW-1:0] StrideReset = 32'd1024;

  localparam logic [ByteW-1:0] ChrGt    = 8'h3E;
  localparam logic [ByteW-1:0] ChrCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChrLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChrTab   = 8'h09;
  localparam logic [ByteW-1:0] ChrSpace = 8'h20;

  localparam int unsigned PushSlots = 3;
  localparam int unsigned FifoDepth = 4;

  typedef enum logic [KindW-1:0] {
    KIND_CHECKPOINT = 2'd0,
    KIND_CONTIG     = 2'd1,
    KIND_TOTALS     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            record_kind;
    logic [PosW-1:0]  file_position;
    logic [CntW-1:0]  base_position;
    logic [CntW-1:0]  contig_start;
    logic [CntW-1:0]  contig_stop;
    logic [CntW-1:0]  first_checkpoint_index;
    logic             length_overflow;
    logic             last_of_run;
  } rec_t;

  typedef struct packed {
    logic [PushSlots-1:0] valid;
    rec_t [PushSlots-1:0] rec;
  } push_t;

endpackage

// ----- sv/fsi_byte_if.sv -----
// Input byte channel of the FASTA stream indexer.
interface fsi_byte_if import fsi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

// ----- sv/fsi_rec_if.sv -----
// Index record channel of the FASTA stream indexer.
interface fsi_rec_if import fsi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] record_kind;
  logic [PosW-1:0]  file_position;
  logic [CntW-1:0]  base_position;
  logic [CntW-1:0]  contig_start;
  logic [CntW-1:0]  contig_stop;
  logic [CntW-1:0]  first_checkpoint_index;
  logic             length_overflow;
  logic             last_of_run;

  modport source (
    output valid, output record_kind, output file_position, output base_position,
    output contig_start, output contig_stop, output first_checkpoint_index,
    output length_overflow, output last_of_run, input ready
  );
  modport sink (
    input valid, input record_kind, input file_position, input base_position,
    input contig_start, input contig_stop, input first_checkpoint_index,
    input length_overflow, input last_of_run, output ready
  );
endinterface

// ----- sv/fsi_cfg_if.sv -----
// Configuration write channel of the FASTA stream indexer.
interface fsi_cfg_if import fsi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StrideW-1:0] stride;

  modport source (output valid, output stride, input ready);
  modport sink (input valid, input stride, output ready);
endinterface

// ----- sv/fsi_core.sv -----
// Input register, stream state and per-byte record generation.
module fsi_core import fsi_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDefault,
  parameter int unsigned BASE_BITS   = BaseBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fsi_byte_if.sink           bytes_i,
  input  logic [StrideW-1:0] stride_i,
  input  logic               space_ok_i,
  output push_t              push_o
);

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_CR    = 2'd1,
    MODE_HEAD  = 2'd2,
    MODE_SEQ   = 2'd3
  } mode_e;

  localparam int unsigned DueBits = StrideW + 1;
  localparam logic [BASE_BITS-1:0] BaseMax = '1;

  logic                   vld_q;
  logic [ByteW-1:0]       byte_q;
  logic                   eof_q;
  mode_e                  mode_q, mode_d, mode_n;
  logic                   open_q, open_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [BASE_BITS-1:0]   base_q, base_d;
  logic [DueBits-1:0]     due_q, due_d;
  logic [BASE_BITS-1:0]   cstart_q, cstart_d;
  logic [CntW-1:0]        cfirst_q, cfirst_d;
  logic [CntW-1:0]        ctotal_q, ctotal_d;

  logic fire, take_in;
  logic is_lf, is_gt, is_cr, is_ws;
  logic hdr_line, start_seq, take, hdr_close, do_open, counts, ckpt;
  logic [DueBits-1:0] due1;
  logic               ovf_new, ovf_old;

  assign fire    = vld_q && space_ok_i;
  assign take_in = !vld_q || fire;
  assign bytes_i.ready = take_in;

  always_comb begin
    is_lf = (byte_q == ChrLf);
    is_gt = (byte_q == ChrGt);
    is_cr = (byte_q == ChrCr);
    is_ws = (byte_q == ChrSpace) || ((byte_q >= ChrTab) && (byte_q <= ChrCr));
    hdr_line  = 1'b0;
    start_seq = 1'b0;
    take      = 1'b0;
    mode_n    = mode_q;
    unique case (mode_q)
      MODE_START: begin
        if (is_gt) begin
          hdr_line = 1'b1;
          mode_n   = MODE_HEAD;
        end else if (is_cr) begin
          mode_n = MODE_CR;
        end else if (!is_lf) begin
          start_seq = 1'b1;
        end
      end
      MODE_CR: begin
        if (is_lf) begin
          mode_n = MODE_START;
        end else if (!is_cr) begin
          start_seq = 1'b1;
        end
      end
      MODE_HEAD: begin
        if (is_lf) begin
          mode_n = MODE_START;
        end
      end
      MODE_SEQ: begin
        if (is_lf) begin
          mode_n = MODE_START;
        end else begin
          take = 1'b1;
        end
      end
      default: mode_n = MODE_START;
    endcase
    if (start_seq) begin
      take   = 1'b1;
      mode_n = MODE_SEQ;
    end

    hdr_close = hdr_line && open_q;
    do_open   = hdr_line || (start_seq && !open_q);
    open_d    = open_q || do_open;
    cstart_d  = do_open ? base_q : cstart_q;
    cfirst_d  = do_open ? ctotal_q : cfirst_q;
    due1      = do_open ? DueBits'(base_q) : due_q;

    counts   = take && !is_ws;
    ckpt     = counts && (DueBits'(base_q) >= due1);
    ctotal_d = ctotal_q + CntW'(ckpt);
    due_d    = ckpt ? (DueBits'(base_q) + DueBits'(stride_i)) : due1;
    base_d   = (counts && (base_q != BaseMax)) ? (base_q + 1'b1) : base_q;
    offset_d = offset_q + 1'b1;
    mode_d   = mode_n;
    ovf_old  = (base_q == BaseMax);
    ovf_new  = (base_d == BaseMax);

    push_o = '0;
    push_o.valid[0] = fire && (hdr_close || ckpt);
    if (hdr_close) begin
      push_o.rec[0].record_kind            = KIND_CONTIG;
      push_o.rec[0].contig_start           = CntW'(cstart_q);
      push_o.rec[0].contig_stop            = CntW'(base_q);
      push_o.rec[0].first_checkpoint_index = cfirst_q;
      push_o.rec[0].length_overflow        = ovf_old;
    end else begin
      push_o.rec[0].record_kind   = KIND_CHECKPOINT;
      push_o.rec[0].file_position = PosW'(offset_q);
      push_o.rec[0].base_position = CntW'(base_q);
    end
    push_o.rec[0].last_of_run = !eof_q;

    push_o.valid[1] = fire && eof_q && open_d;
    push_o.rec[1].record_kind            = KIND_CONTIG;
    push_o.rec[1].contig_start           = CntW'(cstart_d);
    push_o.rec[1].contig_stop            = CntW'(base_d);
    push_o.rec[1].first_checkpoint_index = cfirst_d;
    push_o.rec[1].length_overflow        = ovf_new;

    push_o.valid[2] = fire && eof_q;
    push_o.rec[2].record_kind            = KIND_TOTALS;
    push_o.rec[2].file_position          = PosW'(offset_d);
    push_o.rec[2].base_position          = CntW'(base_d);
    push_o.rec[2].first_checkpoint_index = ctotal_d;
    push_o.rec[2].length_overflow        = ovf_new;
    push_o.rec[2].last_of_run            = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      mode_q   <= MODE_START;
      open_q   <= 1'b0;
      offset_q <= '0;
      base_q   <= '0;
      due_q    <= '0;
      cstart_q <= '0;
      cfirst_q <= '0;
      ctotal_q <= '0;
    end else begin
      if (take_in) begin
        vld_q <= bytes_i.valid;
      end
      if (fire) begin
        if (eof_q) begin
          mode_q   <= MODE_START;
          open_q   <= 1'b0;
          offset_q <= '0;
          base_q   <= '0;
          due_q    <= '0;
          cstart_q <= '0;
          cfirst_q <= '0;
          ctotal_q <= '0;
        end else begin
          mode_q   <= mode_d;
          open_q   <= open_d;
          offset_q <= offset_d;
          base_q   <= base_d;
          due_q    <= due_d;
          cstart_q <= cstart_d;
          cfirst_q <= cfirst_d;
          ctotal_q <= ctotal_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      byte_q <= bytes_i.data_byte;
      eof_q  <= bytes_i.end_of_file;
    end
  end

endmodule

// ----- sv/fsi_rec_fifo.sv -----
// Record queue that takes up to three records per cycle and sends one per beat.
module fsi_rec_fifo import fsi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      space_ok_o,
  fsi_rec_if.source recs_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntBits = $clog2(FifoDepth + 1);

  rec_t mem_q [FifoDepth];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0]    pos [PushSlots];
  logic [CntBits-1:0] n_push;
  logic               pop;
  rec_t               head;

  always_comb begin
    pos[0] = wr_q;
    pos[1] = wr_q + PtrW'(push_i.valid[0]);
    pos[2] = pos[1] + PtrW'(push_i.valid[1]);
    n_push = CntBits'(push_i.valid[0]) + CntBits'(push_i.valid[1])
           + CntBits'(push_i.valid[2]);
    wr_d   = wr_q + PtrW'(n_push);
    cnt_d  = cnt_q + n_push - CntBits'(pop);
  end

  assign space_ok_o = (cnt_q <= CntBits'(FifoDepth - PushSlots));
  assign head       = mem_q[rd_q];
  assign pop        = recs_o.valid && recs_o.ready;

  assign recs_o.valid                  = (cnt_q != '0);
  assign recs_o.record_kind            = head.record_kind;
  assign recs_o.file_position          = head.file_position;
  assign recs_o.base_position          = head.base_position;
  assign recs_o.contig_start           = head.contig_start;
  assign recs_o.contig_stop            = head.contig_stop;
  assign recs_o.first_checkpoint_index = head.first_checkpoint_index;
  assign recs_o.length_overflow        = head.length_overflow;
  assign recs_o.last_of_run            = head.last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PushSlots; i++) begin
      if (push_i.valid[i]) begin
        mem_q[pos[i]] <= push_i.rec[i];
      end
    end
  end

endmodule

// ----- sv/fasta_stream_indexer.sv -----
// Top level of the FASTA stream indexer.
// The bytes_i channel takes one byte of a FASTA file per beat; end_of_file
// marks the last byte. The records_o channel sends checkpoint, contig-closed
// and end-totals records, with last_of_run set on the final record that a
// byte causes. The cfg_i channel writes the checkpoint stride; it is always
// ready and should only be written while no byte is in flight.
// A byte waits in the input register until the queue has room; its records
// are then written from there into a four-entry record queue, which sends
// them to the receiver in the order they were written. One byte is taken per cycle
// while the queue holds at most one record; a byte that yields several
// records holds the input until the queue is down to one record again.
// When the receiver stalls, the queue keeps up to four records and one more
// byte can be taken while a single record waits. Reset empties the queue,
// returns the stream state to the start of a file and sets the stride to 1024.
// After the end-of-file byte the stream state returns to its reset values.
module fasta_stream_indexer import fsi_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDefault,
  parameter int unsigned BASE_BITS   = BaseBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fsi_byte_if.sink  bytes_i,
  fsi_cfg_if.sink   cfg_i,
  fsi_rec_if.source records_o
);

  logic [StrideW-1:0] stride_q;
  logic               space_ok;
  push_t              push;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= StrideReset;
    end else if (cfg_i.valid) begin
      stride_q <= cfg_i.stride;
    end
  end

  fsi_core #(
    .OFFSET_BITS(OFFSET_BITS),
    .BASE_BITS  (BASE_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .bytes_i   (bytes_i),
    .stride_i  (stride_q),
    .space_ok_i(space_ok),
    .push_o    (push)
  );

  fsi_rec_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .space_ok_o(space_ok),
    .recs_o    (records_o)
  );

endmodule
